// File: rtl/rlbd_pkg.sv
`default_nettype none

package rlbd_pkg;

  // Item modes
  typedef enum logic [1:0] {
    MODE_SAMPLE       = 2'd0,
    MODE_TAKE_PRESS   = 2'd1,
    MODE_TAKE_RELEASE = 2'd2
  } mode_t;

  localparam int unsigned ADC_W  = 10;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DEB_W  = 16;

  localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

  // Ladder thresholds
  localparam logic [ADC_W-1:0] THR_IDLE_MAX = 10'd100;
  localparam logic [ADC_W-1:0] THR_B2       = 10'd200;
  localparam logic [ADC_W-1:0] THR_B3       = 10'd300;
  localparam logic [ADC_W-1:0] THR_B4       = 10'd450;
  localparam logic [ADC_W-1:0] THR_B5       = 10'd600;
  localparam logic [ADC_W-1:0] THR_B6       = 10'd800;
  localparam logic [ADC_W-1:0] THR_GAP      = 10'd900;
  localparam logic [ADC_W-1:0] THR_GAP_MAX  = 10'd1000;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

  typedef struct packed {
    mode_t              mode;
    logic [ADC_W-1:0]   adc_sample;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] button_state;
    logic              event_valid;
    logic [CODE_W-1:0] event_button;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/rlbd_ladder_decode.sv
`default_nettype none

module rlbd_ladder_decode (
  input  wire logic [rlbd_pkg::ADC_W-1:0]  sample,
  output logic      [rlbd_pkg::CODE_W-1:0] code
);
  import rlbd_pkg::*;

  // Map the ladder voltage to a button code; the gap band reads as no button
  always_comb begin
    priority if (sample <= THR_IDLE_MAX) code = CODE_NONE;
    else if (sample < THR_B2)            code = 3'd1;
    else if (sample < THR_B3)            code = 3'd2;
    else if (sample < THR_B4)            code = 3'd3;
    else if (sample < THR_B5)            code = 3'd4;
    else if (sample < THR_B6)            code = 3'd5;
    else if (sample < THR_GAP)           code = 3'd6;
    else if (sample > THR_GAP_MAX)       code = 3'd7;
    else                                 code = CODE_NONE;
  end

endmodule

`default_nettype wire

// File: rtl/rlbd_core.sv
`default_nettype none

module rlbd_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         advance,
  input  wire rlbd_pkg::in_item_t           item,
  input  wire logic [rlbd_pkg::DEB_W-1:0]   debounce_time,
  output rlbd_pkg::out_item_t               result
);
  import rlbd_pkg::*;

  logic [CODE_W-1:0] stable_r, stable_nxt;
  logic [TIME_W-1:0] last_change_r, last_change_nxt;
  logic [CODE_W-1:0] press_r, press_nxt;
  logic [CODE_W-1:0] release_r, release_nxt;
  logic [CODE_W-1:0] code;
  logic [TIME_W-1:0] elapsed;
  logic              change;

  rlbd_ladder_decode u_decode (
    .sample (item.adc_sample),
    .code   (code)
  );

  // Wrapping elapsed time since the last accepted change
  assign elapsed = item.now_ms - last_change_r;
  assign change  = (elapsed > {{(TIME_W-DEB_W){1'b0}}, debounce_time}) && (code != stable_r);

  always_comb begin
    stable_nxt          = stable_r;
    last_change_nxt     = last_change_r;
    press_nxt           = press_r;
    release_nxt         = release_r;
    result.event_valid  = 1'b0;
    result.event_button = CODE_NONE;
    unique case (item.mode)
      MODE_SAMPLE: begin
        if (change) begin
          stable_nxt      = code;
          last_change_nxt = item.now_ms;
          if (code != CODE_NONE) press_nxt = code;
          else                   release_nxt = stable_r;
        end
      end
      MODE_TAKE_PRESS: begin
        if (press_r != CODE_NONE) begin
          result.event_valid  = 1'b1;
          result.event_button = press_r;
          press_nxt           = CODE_NONE;
        end
      end
      MODE_TAKE_RELEASE: begin
        if (release_r != CODE_NONE) begin
          result.event_valid  = 1'b1;
          result.event_button = release_r;
          release_nxt         = CODE_NONE;
        end
      end
      default: ;
    endcase
    result.button_state = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= CODE_NONE;
      last_change_r <= '0;
      press_r       <= CODE_NONE;
      release_r     <= CODE_NONE;
    end else if (advance) begin
      stable_r      <= stable_nxt;
      last_change_r <= last_change_nxt;
      press_r       <= press_nxt;
      release_r     <= release_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/resistor_ladder_button_debouncer.sv
`default_nettype none

// Resistor-ladder keypad decoder with debounce and press/release event latches.
// Each item is registered on entry, then decoded and applied to the debounce
// state in the same cycle that it moves into the result register, so the block
// takes one item per clock while out_stall is low. A result passes through the
// input register and then the result register, with the state update between
// them, before it reaches the outputs. A stalled result holds the input
// register, so at most two items wait inside the block.
// A mode 0 item decodes the ten-bit sample and accepts a change of the
// debounced code only once more than debounce_time ms (wrapping 32-bit time)
// have passed since the last accepted change; a new nonzero code latches a
// press, a drop to zero latches the released code. Mode 1 and mode 2 items take
// and clear the press or release latch. Write debounce_time (reset 50) only
// while no item is in flight; cfg_ready is always high.
module resistor_ladder_button_debouncer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rlbd_pkg::in_item_t          in_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rlbd_pkg::out_item_t              out_item,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rlbd_pkg::DEB_W-1:0]  cfg_debounce_time
);
  import rlbd_pkg::*;

  logic              in_valid_r;
  in_item_t          in_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  out_item_t         result;
  logic [DEB_W-1:0]  debounce_r;
  logic              advance;

  // Move the held item into the result register whenever that slot is free
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Hold the debounce time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce_r <= cfg_debounce_time;
    end
  end

  // Input register: take a new item whenever the current one leaves or none is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  rlbd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .item          (in_item_r),
    .debounce_time (debounce_r),
    .result        (result)
  );

  // Result register: drop the item once taken, load the next on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule

`default_nettype wire
